// File: rtl/lagrange_interpolator_core_defines.svh
// Assertion macros shared by the interpolator RTL.
`ifndef LAGRANGE_INTERPOLATOR_CORE_DEFINES_SVH
`define LAGRANGE_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define LIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define LIC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lic_pkg.sv
// Types, codes and the step program of the Lagrange interpolator.
package lic_pkg;

	localparam int ACC_W  = 80;
	localparam int FREQ_W = 23;
	localparam int CAP_W  = 6;
	localparam int DIFF_W = 24;
	localparam int DIG_W  = 8;
	localparam int NDIG   = DIFF_W / DIG_W;

	localparam logic [1:0] MAX_POINTS = 2'd3;

	// register indexes
	localparam logic [2:0] REG_POINT_COUNT = 3'd0;
	localparam logic [2:0] REG_FREQ_0      = 3'd1;
	localparam logic [2:0] REG_FREQ_1      = 3'd2;
	localparam logic [2:0] REG_FREQ_2      = 3'd3;
	localparam logic [2:0] REG_CAP_0       = 3'd4;
	localparam logic [2:0] REG_CAP_1       = 3'd5;
	localparam logic [2:0] REG_CAP_2       = 3'd6;

	// multiplicand sources
	localparam logic [2:0] MC_ONE = 3'd0;
	localparam logic [2:0] MC_D0  = 3'd1;
	localparam logic [2:0] MC_D1  = 3'd2;
	localparam logic [2:0] MC_A   = 3'd3;
	localparam logic [2:0] MC_T   = 3'd4;

	// multiplier sources
	localparam logic [3:0] MP_ONE = 4'd0;
	localparam logic [3:0] MP_D1  = 4'd1;
	localparam logic [3:0] MP_D2  = 4'd2;
	localparam logic [3:0] MP_C0  = 4'd3;
	localparam logic [3:0] MP_C1  = 4'd4;
	localparam logic [3:0] MP_C2  = 4'd5;
	localparam logic [3:0] MP_A   = 4'd6;
	localparam logic [3:0] MP_B   = 4'd7;
	localparam logic [3:0] MP_C   = 4'd8;

	// what happens to the finished product
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_SET_NUM = 2'd1;
	localparam logic [1:0] ACT_ADD_NUM = 2'd2;
	localparam logic [1:0] ACT_SET_DEN = 2'd3;

	typedef struct packed {
		logic [2:0] mc_sel;
		logic [3:0] mp_sel;
		logic       neg;
		logic [1:0] act;
		logic       last;
	} step_ctl_t;

	function automatic step_ctl_t mk(input logic [2:0] mc, input logic [3:0] mp,
			input logic neg, input logic [1:0] act, input logic last);
		step_ctl_t s;
		s.mc_sel = mc;
		s.mp_sel = mp;
		s.neg    = neg;
		s.act    = act;
		s.last   = last;
		return s;
	endfunction

	// One product per step; n is the number of points in use.
	function automatic step_ctl_t step_ctl(input logic [1:0] n, input logic [3:0] idx);
		step_ctl_t s;
		s = mk(MC_ONE, MP_ONE, 1'b0, ACT_SET_DEN, 1'b1);
		if (n == 2'd1) begin
			unique case (idx)
				4'd0:    s = mk(MC_ONE, MP_C0, 1'b0, ACT_SET_NUM, 1'b0);
				default: s = mk(MC_ONE, MP_ONE, 1'b0, ACT_SET_DEN, 1'b1);
			endcase
		end else if (n == 2'd2) begin
			unique case (idx)
				4'd0:    s = mk(MC_D1, MP_C0, 1'b0, ACT_SET_NUM, 1'b0);
				4'd1:    s = mk(MC_D0, MP_C1, 1'b1, ACT_ADD_NUM, 1'b0);
				default: s = mk(MC_A, MP_ONE, 1'b0, ACT_SET_DEN, 1'b1);
			endcase
		end else begin
			unique case (idx)
				4'd0:    s = mk(MC_D1, MP_D2, 1'b0, ACT_NONE, 1'b0);
				4'd1:    s = mk(MC_T, MP_C0, 1'b0, ACT_NONE, 1'b0);
				4'd2:    s = mk(MC_T, MP_C, 1'b0, ACT_SET_NUM, 1'b0);
				4'd3:    s = mk(MC_D0, MP_D2, 1'b0, ACT_NONE, 1'b0);
				4'd4:    s = mk(MC_T, MP_C1, 1'b0, ACT_NONE, 1'b0);
				4'd5:    s = mk(MC_T, MP_B, 1'b1, ACT_ADD_NUM, 1'b0);
				4'd6:    s = mk(MC_D0, MP_D1, 1'b0, ACT_NONE, 1'b0);
				4'd7:    s = mk(MC_T, MP_C2, 1'b0, ACT_NONE, 1'b0);
				4'd8:    s = mk(MC_T, MP_A, 1'b0, ACT_ADD_NUM, 1'b0);
				4'd9:    s = mk(MC_A, MP_B, 1'b0, ACT_NONE, 1'b0);
				default: s = mk(MC_T, MP_C, 1'b0, ACT_SET_DEN, 1'b1);
			endcase
		end
		return s;
	endfunction

endpackage

// File: rtl/lagrange_interpolator_core.sv
// One query in flight: colliding points or no points in use send a query straight to output, and
// the divide stops early when the value saturates. s_tready returns in the cycle after the result
// is loaded, and a finished result waits in S_OUT while the output register holds one not yet taken.
// One 80x9 multiply-add unit runs each product in three 8-bit digits, and a restoring divide
// yields one quotient bit a cycle. arst_n clears control, loads reset values.
`include "lagrange_interpolator_core_defines.svh"

module lagrange_interpolator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [22:0] query_freq
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] cap_code
	output logic [1:0]  m_tuser,   // [0] clipped, [1] bad_points
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	localparam int AW = lic_pkg::ACC_W;
	localparam int DW = lic_pkg::DIFF_W;
	localparam int GW = lic_pkg::DIG_W;
	localparam int FW = lic_pkg::FREQ_W;
	localparam int CW = lic_pkg::CAP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_POST = 3'd3;
	localparam logic [2:0] S_SIGN = 3'd4;
	localparam logic [2:0] S_PREP = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [1:0]          pcount_q;
	logic [FW-1:0]       freq_q [3];
	logic [CW-1:0]       cap_q  [3];

	logic [2:0]          state_q;
	logic [FW-1:0]       query_q;
	logic [1:0]          npts_q;
	logic [3:0]          step_q;
	logic [1:0]          dig_q;
	logic [2:0]          bit_q;
	logic signed [AW-1:0] mcand_q;
	logic [DW-1:0]       mplier_q;
	logic signed [AW-1:0] t_q;
	logic signed [AW-1:0] num_q;
	logic signed [AW-1:0] den_q;
	logic [CW-1:0]       code_q;
	logic                clip_q;
	logic                bad_q;
	logic                m_tvalid_q;
	logic [7:0]          m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic [1:0]          n_eff;
	logic                bad_now;
	logic signed [DW-1:0] d0, d1, d2, da, db, dc;
	lic_pkg::step_ctl_t  ctl;
	logic signed [AW-1:0] mc_src;
	logic signed [DW-1:0] mp_src;
	logic [DW-1:0]       mp_mag;
	logic                mp_neg;
	logic signed [AW-1:0] pp;
	logic signed [AW-1:0] t_next;
	logic signed [AW-1:0] m_val;
	logic signed [AW-1:0] diff;
	logic                take;
	logic                out_free;
	logic                in_xfer;

	assign n_eff = (pcount_q > lic_pkg::MAX_POINTS) ? lic_pkg::MAX_POINTS : pcount_q;
	assign bad_now = ((n_eff >= 2'd2) && (freq_q[0] == freq_q[1])) ||
		((n_eff == 2'd3) && ((freq_q[0] == freq_q[2]) || (freq_q[1] == freq_q[2])));

	assign d0 = $signed({1'b0, query_q}) - $signed({1'b0, freq_q[0]});
	assign d1 = $signed({1'b0, query_q}) - $signed({1'b0, freq_q[1]});
	assign d2 = $signed({1'b0, query_q}) - $signed({1'b0, freq_q[2]});
	assign da = $signed({1'b0, freq_q[0]}) - $signed({1'b0, freq_q[1]});
	assign db = $signed({1'b0, freq_q[0]}) - $signed({1'b0, freq_q[2]});
	assign dc = $signed({1'b0, freq_q[1]}) - $signed({1'b0, freq_q[2]});

	assign ctl = lic_pkg::step_ctl(npts_q, step_q);

	always_comb begin
		unique case (ctl.mc_sel)
			lic_pkg::MC_D0: mc_src = AW'(d0);
			lic_pkg::MC_D1: mc_src = AW'(d1);
			lic_pkg::MC_A:  mc_src = AW'(da);
			lic_pkg::MC_T:  mc_src = t_q;
			default:        mc_src = AW'(1);
		endcase
	end

	always_comb begin
		unique case (ctl.mp_sel)
			lic_pkg::MP_D1: mp_src = d1;
			lic_pkg::MP_D2: mp_src = d2;
			lic_pkg::MP_C0: mp_src = $signed({{(DW-CW){1'b0}}, cap_q[0]});
			lic_pkg::MP_C1: mp_src = $signed({{(DW-CW){1'b0}}, cap_q[1]});
			lic_pkg::MP_C2: mp_src = $signed({{(DW-CW){1'b0}}, cap_q[2]});
			lic_pkg::MP_A:  mp_src = da;
			lic_pkg::MP_B:  mp_src = db;
			lic_pkg::MP_C:  mp_src = dc;
			default:        mp_src = DW'(1);
		endcase
	end

	// multiply by the magnitude, fold the sign into the multiplicand
	assign mp_neg = mp_src[DW-1] ^ ctl.neg;
	assign mp_mag = mp_src[DW-1] ? DW'(-mp_src) : mp_src;

	// MSB-first digit step; modular arithmetic is exact since the final value fits
	assign pp     = mcand_q * $signed({1'b0, mplier_q[DW-1 -: GW]});
	assign t_next = (t_q <<< GW) + pp;

	assign m_val = (num_q <<< 1) + den_q;
	assign diff  = num_q - den_q;
	assign take  = !diff[AW-1];

	assign out_free = !m_tvalid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= 2'd3;
			freq_q[0] <= '0;
			freq_q[1] <= '0;
			freq_q[2] <= '0;
			cap_q[0]  <= '0;
			cap_q[1]  <= '0;
			cap_q[2]  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				lic_pkg::REG_POINT_COUNT: pcount_q  <= cfg_data[1:0];
				lic_pkg::REG_FREQ_0:      freq_q[0] <= cfg_data;
				lic_pkg::REG_FREQ_1:      freq_q[1] <= cfg_data;
				lic_pkg::REG_FREQ_2:      freq_q[2] <= cfg_data;
				lic_pkg::REG_CAP_0:       cap_q[0]  <= cfg_data[CW-1:0];
				lic_pkg::REG_CAP_1:       cap_q[1]  <= cfg_data[CW-1:0];
				lic_pkg::REG_CAP_2:       cap_q[2]  <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			npts_q  <= '0;
			step_q  <= '0;
			dig_q   <= '0;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						npts_q <= n_eff;
						step_q <= '0;
						if ((n_eff == 2'd0) || bad_now) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					dig_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					dig_q <= dig_q + 2'd1;
					if (dig_q == 2'(lic_pkg::NDIG - 1)) begin
						if (ctl.act == lic_pkg::ACT_NONE) begin
							step_q  <= step_q + 4'd1;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					if (ctl.last) begin
						state_q <= S_SIGN;
					end else begin
						step_q  <= step_q + 4'd1;
						state_q <= S_LOAD;
					end
				end
				S_SIGN: state_q <= S_PREP;
				S_PREP: begin
					bit_q   <= 3'd6;
					state_q <= m_val[AW-1] ? S_OUT : S_DIV;
				end
				S_DIV: begin
					bit_q <= bit_q - 3'd1;
					if (((bit_q == 3'd6) && take) || (bit_q == 3'd0)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				query_q <= s_tdata[FW-1:0];
				code_q  <= '0;
				clip_q  <= 1'b0;
				bad_q   <= bad_now && (n_eff != 2'd0);
			end
			S_LOAD: begin
				mcand_q  <= mp_neg ? -mc_src : mc_src;
				mplier_q <= mp_mag;
				t_q      <= '0;
			end
			S_MUL: begin
				t_q      <= t_next;
				mplier_q <= mplier_q << GW;
			end
			S_POST: begin
				unique case (ctl.act)
					lic_pkg::ACT_SET_NUM: num_q <= t_q;
					lic_pkg::ACT_ADD_NUM: num_q <= num_q + t_q;
					lic_pkg::ACT_SET_DEN: den_q <= t_q;
					default: ;
				endcase
			end
			S_SIGN: begin
				if (den_q[AW-1]) begin
					num_q <= -num_q;
					den_q <= -den_q;
				end
			end
			S_PREP: begin
				// remainder 2*num + den against divisor 2*den, top quotient bit first
				num_q  <= m_val;
				den_q  <= den_q <<< 7;
				clip_q <= m_val[AW-1];
			end
			S_DIV: begin
				den_q <= den_q >>> 1;
				if (bit_q == 3'd6) begin
					if (take) begin
						code_q <= '1;
						clip_q <= 1'b1;
					end
				end else begin
					if (take) begin
						num_q <= diff;
					end
					code_q <= {code_q[CW-2:0], take};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			m_tdata_q <= {2'b00, code_q};
			m_tuser_q <= {bad_q, clip_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`LIC_ASSERT_NOW(a_bad_zero, m_tvalid && m_tuser[1], (m_tdata[5:0] == 6'd0) && !m_tuser[0], "bad points result must be code 0 unclipped")
	`LIC_ASSERT_NOW(a_clip_rail, m_tvalid && m_tuser[0], (m_tdata[5:0] == 6'd0) || (m_tdata[5:0] == 6'd63), "clipped code must sit on a rail")
	`LIC_ASSERT_NOW(a_den_pos, state_q == S_PREP, !den_q[AW-1] && (den_q != '0), "divisor must be positive after sign fix")
	`LIC_ASSERT_NOW(a_rem_pos, state_q == S_DIV, !num_q[AW-1], "remainder went negative in divide")
	`LIC_ASSERT_NXT(a_busy, s_tvalid && s_tready, state_q != S_IDLE, "accepted query did not start")

endmodule
